FILE: rtl/core/ssb_pkg.sv
package ssb_pkg;

	localparam int unsigned REG_W   = 11;
	localparam int unsigned COORD_W = 10;
	localparam int unsigned STORE_AW = 14;
	localparam int unsigned TEXEL_W = 16;
	localparam int unsigned ADDR_W  = 20;

	typedef enum logic [2:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_TARGET_LEFT   = 3'd2,
		REG_TARGET_TOP    = 3'd3,
		REG_TARGET_WIDTH  = 3'd4,
		REG_TARGET_HEIGHT = 3'd5
	} reg_idx_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	// Work item handed from the front end to the blit back end.
	typedef struct packed {
		logic                 is_load;
		logic [STORE_AW-1:0]  load_index;
		logic [TEXEL_W-1:0]   load_texel;
		logic [COORD_W-1:0]   col;
		logic [COORD_W-1:0]   row;
		logic [REG_W-1:0]     px;
		logic [REG_W-1:0]     py;
	} work_t;

	// 5-bit channel to 8 bits, c*255/31.
	function automatic logic [7:0] expand5(input logic [4:0] c);
		logic [12:0] p;
		logic [26:0] m;
		begin
			p = 13'(c) * 13'd255;
			// Division by 31 as a multiply by 2^18/31 rounded up; exact for p below 11397.
			m = 27'(p) * 27'd8457;
			expand5 = m[25:18];
		end
	endfunction

	function automatic logic [7:0] expand6(input logic [5:0] c);
		logic [13:0] p;
		logic [28:0] m;
		begin
			p = 14'(c) * 14'd255;
			// Division by 63 as a multiply by 2^20/63 rounded up; exact for p below 17772.
			m = 29'(p) * 29'd16645;
			expand6 = m[27:20];
		end
	endfunction

endpackage

FILE: rtl/core/ssb_div.sv
// Restoring divider, one quotient bit per stage, fully pipelined.
module ssb_div import ssb_pkg::*; #(
	parameter int unsigned NUM_W = 18,
	parameter int unsigned DEN_W = 11,
	parameter int unsigned TAG_W = 8
) (
	input  logic             clk,
	input  logic             adv,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag,
	output logic [NUM_W-1:0] quo,
	output logic [TAG_W-1:0] tag_out
);

	logic [NUM_W-1:0] q_s [NUM_W+1];
	logic [DEN_W:0]   r_s [NUM_W+1];
	logic [NUM_W-1:0] n_s [NUM_W+1];
	logic [DEN_W-1:0] d_s [NUM_W+1];
	logic [TAG_W-1:0] t_s [NUM_W+1];

	assign q_s[0] = '0;
	assign r_s[0] = '0;
	assign n_s[0] = num;
	assign d_s[0] = den;
	assign t_s[0] = tag;

	for (genvar i = 0; i < NUM_W; i++) begin : g_st
		logic [DEN_W+1:0] sh;
		logic [DEN_W+1:0] df;
		assign sh = {r_s[i], n_s[i][NUM_W-1-i]};
		assign df = sh - {2'b00, d_s[i]};
		always_ff @(posedge clk) begin
			if (adv) begin
				n_s[i+1] <= n_s[i];
				d_s[i+1] <= d_s[i];
				t_s[i+1] <= t_s[i];
				if (!df[DEN_W+1]) begin
					r_s[i+1] <= df[DEN_W:0];
					q_s[i+1] <= q_s[i] | (NUM_W'(1) << (NUM_W-1-i));
				end else begin
					r_s[i+1] <= sh[DEN_W:0];
					q_s[i+1] <= q_s[i];
				end
			end
		end
	end

	assign quo = q_s[NUM_W];
	assign tag_out = t_s[NUM_W];

endmodule

FILE: rtl/core/ssb_front.sv
// Classifies requests: loads pass through, draws are clipped and offset.
module ssb_front import ssb_pkg::*; #(
	parameter int unsigned MAX_SCREEN = 1024
) (
	input  logic               opcode,
	input  logic [STORE_AW-1:0] load_index,
	input  logic [TEXEL_W-1:0] load_texel,
	input  logic [COORD_W-1:0] dest_col,
	input  logic [COORD_W-1:0] dest_row,
	input  logic [REG_W-1:0]   sw,
	input  logic [REG_W-1:0]   sh,
	input  logic [REG_W-1:0]   tl,
	input  logic [REG_W-1:0]   tt,
	input  logic [REG_W-1:0]   tw,
	input  logic [REG_W-1:0]   th,
	output logic               keep,
	output work_t              item
);

	localparam int unsigned SAT_W = $clog2(MAX_SCREEN + 1);
	localparam int unsigned CW = (SAT_W > REG_W ? SAT_W : REG_W) + 2;

	logic signed [12:0] pxs, pys;
	logic [CW-1:0] swc, shc;
	logic vis;

	always_comb begin
		pxs = {{2{tl[REG_W-1]}}, tl} + $signed({3'b000, dest_col});
		pys = {{2{tt[REG_W-1]}}, tt} + $signed({3'b000, dest_row});
		swc = (CW'(sw) > CW'(MAX_SCREEN)) ? CW'(MAX_SCREEN) : CW'(sw);
		shc = (CW'(sh) > CW'(MAX_SCREEN)) ? CW'(MAX_SCREEN) : CW'(sh);
		vis = ({1'b0, dest_col} < tw) && ({1'b0, dest_row} < th)
			&& !pxs[12] && !pys[12]
			&& (CW'(pxs[11:0]) < swc) && (CW'(pys[11:0]) < shc);
		keep = (opcode == OP_LOAD) || vis;
		item.is_load = (opcode == OP_LOAD);
		item.load_index = load_index;
		item.load_texel = load_texel;
		item.col = dest_col;
		item.row = dest_row;
		item.px = pxs[REG_W-1:0];
		item.py = pys[REG_W-1:0];
	end

endmodule

FILE: rtl/core/ssb_back.sv
// Blit back end: divide, store read, address and color, output queue.
module ssb_back import ssb_pkg::*; #(
	parameter int unsigned ICON_WIDTH = 128,
	parameter int unsigned ICON_HEIGHT = 128,
	parameter int unsigned MAX_SCREEN = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  work_t              in_item,
	input  logic [REG_W-1:0]   sw,
	input  logic [REG_W-1:0]   tw,
	input  logic [REG_W-1:0]   th,
	output logic               empty,
	input  logic               pop,
	output logic [ADDR_W-1:0]  canvas_addr,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue
);

	localparam int unsigned IWW = $clog2(ICON_WIDTH + 1);
	localparam int unsigned IHW = $clog2(ICON_HEIGHT + 1);
	localparam int unsigned NXW = COORD_W + IWW;
	localparam int unsigned NYW = COORD_W + IHW;
	localparam int unsigned NW = NXW > NYW ? NXW : NYW;
	localparam int unsigned LAT = NW + 3;
	localparam int unsigned ODEPTH = 1 << $clog2(LAT + 2);
	localparam int unsigned OAW = $clog2(ODEPTH);
	localparam int unsigned SAT_W = $clog2(MAX_SCREEN + 1);
	localparam int unsigned TAG_W = 1 + 2 * REG_W;
	localparam int unsigned LTAG_W = STORE_AW + TEXEL_W;

	// Loads travel down the divider pipe beside the draws and write the store
	// as they leave it, so a draw always reads the store as of its own request.
	logic adv;
	logic acc, acc_draw;
	logic [TAG_W-1:0] tag_in, tag_o;
	logic [LTAG_W-1:0] ltag_in, ltag_o;
	logic [NW-1:0] qx, qy;
	logic [STORE_AW-1:0] sidx;
	logic [NW-1:0] vpipe_q;
	logic vo, ld_o;
	logic v_s1, v_s2, v_s3;
	logic drop;
	logic [TEXEL_W-1:0] tex_s2;
	logic [REG_W-1:0] px_s1, px_s2;
	logic [ADDR_W+1:0] rowm_s2;
	logic [REG_W-1:0] py_s1;
	logic [SAT_W-1:0] swc;
	logic [STORE_AW-1:0] sidx_s1;
	logic [ADDR_W-1:0] addr_s3;
	logic [7:0] r_s3, g_s3, b_s3;
	logic [ADDR_W+23:0] oq [ODEPTH];
	logic [OAW-1:0] wp_q, rp_q;
	logic [OAW:0] fill_q;
	logic [OAW:0] occ_q;
	logic do_pop;

	logic [TEXEL_W-1:0] store [1 << STORE_AW];

	assign adv = 1'b1;
	assign acc = in_valid && in_ready;
	assign acc_draw = acc && !in_item.is_load;

	assign tag_in = {in_item.is_load, in_item.px, in_item.py};
	assign ltag_in = {in_item.load_index, in_item.load_texel};

	ssb_div #(.NUM_W(NW), .DEN_W(REG_W), .TAG_W(TAG_W)) u_dx (
		.clk(clk), .adv(adv),
		.num(NW'(in_item.col) * NW'(ICON_WIDTH)), .den(tw), .tag(tag_in),
		.quo(qx), .tag_out(tag_o)
	);
	ssb_div #(.NUM_W(NW), .DEN_W(REG_W), .TAG_W(LTAG_W)) u_dy (
		.clk(clk), .adv(adv),
		.num(NW'(in_item.row) * NW'(ICON_HEIGHT)), .den(th), .tag(ltag_in),
		.quo(qy), .tag_out(ltag_o)
	);

	// Valid bits of the divider pipe, reset-cleared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vpipe_q <= '0;
		else vpipe_q <= {vpipe_q[NW-2:0], acc};
	end

	assign vo = vpipe_q[NW-1];
	assign ld_o = tag_o[TAG_W-1];

	always_ff @(posedge clk) begin
		if (vo && ld_o)
			store[ltag_o[LTAG_W-1:TEXEL_W]] <= ltag_o[TEXEL_W-1:0];
	end

	// Stage 1: store index; stage 2: store read and canvas row multiply.
	assign swc = (32'(sw) > 32'(MAX_SCREEN)) ? SAT_W'(MAX_SCREEN) : SAT_W'(sw);
	assign sidx = STORE_AW'(32'(qy) * ICON_WIDTH + 32'(qx));
	assign drop = v_s2 && (tex_s2 == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else begin
			v_s1 <= vo && !ld_o;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && (tex_s2 != '0);
		end
	end

	always_ff @(posedge clk) begin
		sidx_s1 <= sidx;
		px_s1 <= tag_o[2*REG_W-1:REG_W];
		py_s1 <= tag_o[REG_W-1:0];
		tex_s2 <= store[sidx_s1];
		px_s2 <= px_s1;
		rowm_s2 <= (ADDR_W+2)'(py_s1) * (ADDR_W+2)'(swc);
	end

	always_ff @(posedge clk) begin
		addr_s3 <= ADDR_W'(rowm_s2 + (ADDR_W+2)'(px_s2));
		r_s3 <= expand5(tex_s2[15:11]);
		g_s3 <= expand6(tex_s2[10:5]);
		b_s3 <= expand5(tex_s2[4:0]);
	end

	// Output queue; space is reserved for everything in flight.
	assign do_pop = pop && !empty;
	assign empty = (fill_q == '0);
	assign {canvas_addr, red, green, blue} = oq[rp_q];

	always_ff @(posedge clk) begin
		if (v_s3) oq[wp_q] <= {addr_s3, r_s3, g_s3, b_s3};
	end

	// occ_q counts draws from acceptance until they are popped or found transparent.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; fill_q <= '0; occ_q <= '0;
		end else begin
			if (v_s3) wp_q <= wp_q + 1'b1;
			if (do_pop) rp_q <= rp_q + 1'b1;
			fill_q <= fill_q + (OAW+1)'(v_s3) - (OAW+1)'(do_pop);
			occ_q <= occ_q + (OAW+1)'(acc_draw) - (OAW+1)'(do_pop) - (OAW+1)'(drop);
		end
	end

	assign in_ready = (occ_q < (OAW+1)'(ODEPTH));

endmodule

FILE: rtl/core/scaled_sprite_blit_top.sv
// Scaled sprite blitter. Accepts one request per clock while full is low:
// loads write the 16384-entry icon store, draws are clipped against the
// target rectangle and screen, scaled by two bit-per-stage pipelined
// dividers (18 stages at default icon size) and yield one canvas write
// unless the texel is zero. A result passes the divider stages, three
// more stages and the result queue before it reaches the output ports.
// Throughput is one request per cycle while full is low; full rises only
// once 32 draws sit between input and the popped end of the result queue.
// Configuration must only be written while no draw is in flight.
module scaled_sprite_blit_top import ssb_pkg::*; #(
	parameter int unsigned ICON_WIDTH = 128,
	parameter int unsigned ICON_HEIGHT = 128,
	parameter int unsigned MAX_SCREEN = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                opcode,
	input  logic [STORE_AW-1:0] load_index,
	input  logic [TEXEL_W-1:0]  load_texel,
	input  logic [COORD_W-1:0]  dest_col,
	input  logic [COORD_W-1:0]  dest_row,
	output logic                empty,
	input  logic                pop,
	output logic [ADDR_W-1:0]   canvas_addr,
	output logic [7:0]          red,
	output logic [7:0]          green,
	output logic [7:0]          blue,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [REG_W-1:0]    cfg_data
);

	logic [REG_W-1:0] sw_q, sh_q, tl_q, tt_q, tw_q, th_q;
	logic keep, rdy;
	work_t item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= REG_W'(480); sh_q <= REG_W'(320);
			tl_q <= '0; tt_q <= '0;
			tw_q <= REG_W'(128); th_q <= REG_W'(128);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  sw_q <= cfg_data;
				REG_SCREEN_HEIGHT: sh_q <= cfg_data;
				REG_TARGET_LEFT:   tl_q <= cfg_data;
				REG_TARGET_TOP:    tt_q <= cfg_data;
				REG_TARGET_WIDTH:  tw_q <= cfg_data;
				REG_TARGET_HEIGHT: th_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ssb_front #(.MAX_SCREEN(MAX_SCREEN)) u_front (
		.opcode(opcode), .load_index(load_index), .load_texel(load_texel),
		.dest_col(dest_col), .dest_row(dest_row),
		.sw(sw_q), .sh(sh_q), .tl(tl_q), .tt(tt_q), .tw(tw_q), .th(th_q),
		.keep(keep), .item(item)
	);

	ssb_back #(.ICON_WIDTH(ICON_WIDTH), .ICON_HEIGHT(ICON_HEIGHT),
		.MAX_SCREEN(MAX_SCREEN)) u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(push && keep), .in_ready(rdy),
		.in_item(item), .sw(sw_q), .tw(tw_q), .th(th_q),
		.empty(empty), .pop(pop), .canvas_addr(canvas_addr),
		.red(red), .green(green), .blue(blue)
	);

	assign full = !rdy;

endmodule

FILE: rtl/core/ssb_checker.sv
module ssb_checker (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic empty,
	input logic pop
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("queue not empty in reset");
	a_reset_ready: assert property (@(posedge clk) !arst_n |=> !full)
		else $error("full right after reset");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result lost without pop");

endmodule

bind scaled_sprite_blit_top ssb_checker u_chk (
	.clk(clk), .arst_n(arst_n), .push(push), .full(full), .empty(empty), .pop(pop)
);
